// ===== design/five_point_stencil_stream_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Five-point stencil stream unit: assertion macros
// Concurrent check macros used by the stencil stream top level. They reduce to
// nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FIVE_POINT_STENCIL_STREAM_UNIT_ASSERT_SVH
`define FIVE_POINT_STENCIL_STREAM_UNIT_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication: when cond holds, prop holds too.
`define FPS_ASSERT_IMPLIES(label, ck, rstn, cond, prop) \
    label: assert property (@(posedge ck) disable iff (!(rstn)) (cond) |-> (prop)) \
        else $error("five point stencil check failed");

// Next-cycle implication: when cond holds, prop holds in the following cycle.
`define FPS_ASSERT_NEXT(label, ck, rstn, cond, prop) \
    label: assert property (@(posedge ck) disable iff (!(rstn)) (cond) |=> (prop)) \
        else $error("five point stencil check failed");

`else

`define FPS_ASSERT_IMPLIES(label, ck, rstn, cond, prop)
`define FPS_ASSERT_NEXT(label, ck, rstn, cond, prop)

`endif

`endif

// ===== design/fps_pkg.sv =====
// ----------------------------------------------------------------------------
// Five-point stencil stream package
// Widths, register codes, shared types and helper functions.
// ----------------------------------------------------------------------------
package fps_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int MAX_ROW_LENGTH  = 1024;
    localparam int ROW_COUNT_LIMIT = 1024;
    localparam int MIN_DIM         = 3;
    localparam int DIM_BITS        = 11;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int COL_BITS        = $clog2(MAX_ROW_LENGTH);
    localparam int ROW_BITS        = $clog2(ROW_COUNT_LIMIT);
    localparam int OUT_BITS        = SAMPLE_BITS + 3;
    localparam int LINE_BITS       = 2 * SAMPLE_BITS;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ROW_LENGTH = 2'd0,
        CFG_ROW_COUNT  = 2'd1
    } cfg_reg_t;

    typedef logic        [DIM_BITS-1:0]    dim_t;
    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [OUT_BITS-1:0]    result_t;

    // Raster position of the sample being accepted
    typedef struct packed {
        logic [COL_BITS-1:0] col;
        logic [ROW_BITS-1:0] row;
        logic                interior;
        logic                last;
    } pos_t;

    // Line buffer write request: upper half older row, lower half previous row
    typedef struct packed {
        logic                 en;
        logic [COL_BITS-1:0]  addr;
        logic [LINE_BITS-1:0] data;
    } line_wr_t;

    // Limit a grid dimension to [MIN_DIM, hi]
    function automatic dim_t clamp_dim(dim_t value, dim_t hi);
        dim_t result;
        if (value < DIM_BITS'(MIN_DIM))
            result = DIM_BITS'(MIN_DIM);
        else if (value > hi)
            result = hi;
        else
            result = value;
        return result;
    endfunction

    // Sign-extend a sample to the result width
    function automatic result_t widen(sample_t value);
        return result_t'(value);
    endfunction

endpackage

// ===== design/fps_if.sv =====
// ----------------------------------------------------------------------------
// Five-point stencil stream interfaces
// Valid/ready channels for samples, results and configuration writes.
// ----------------------------------------------------------------------------
interface fps_sample_if;
    logic                     valid;
    logic                     ready;
    logic [fps_pkg::SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface fps_result_if;
    logic                         valid;
    logic                         ready;
    logic [fps_pkg::OUT_BITS-1:0] half_laplacian;
    logic                         last_of_frame;

    modport source (output valid, output half_laplacian, output last_of_frame, input ready);
    modport sink   (input valid, input half_laplacian, input last_of_frame, output ready);
endinterface

interface fps_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [fps_pkg::CFG_INDEX_BITS-1:0] index;
    logic [fps_pkg::DIM_BITS-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/fps_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data held between reads.
// ----------------------------------------------------------------------------
module fps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/fps_position.sv =====
// ----------------------------------------------------------------------------
// Five-point stencil raster position tracker
// Holds the grid dimensions and the column/row of the next sample; flags
// interior positions and the final cell of the grid.
// ----------------------------------------------------------------------------
module fps_position (
    input  logic             clk,
    input  logic             rst_n,
    fps_cfg_if.sink          cfg,
    input  logic             cfg_open,
    input  logic             advance,
    output fps_pkg::pos_t    pos
);

    fps_pkg::dim_t                   row_length_reg, row_length_next;
    fps_pkg::dim_t                   row_count_reg,  row_count_next;
    logic [fps_pkg::COL_BITS-1:0]    col_reg, col_next;
    logic [fps_pkg::ROW_BITS-1:0]    row_reg, row_next;
    logic [fps_pkg::COL_BITS-1:0]    col_cur;
    logic                            col_last;
    logic                            row_last;
    logic                            cfg_fire;

    assign cfg.ready = cfg_open;
    assign cfg_fire  = cfg.valid && cfg_open;

    // Wrap a stale column, then find the row and frame ends
    always_comb
    begin
        if (fps_pkg::dim_t'(col_reg) >= row_length_reg)
            col_cur = '0;
        else
            col_cur = col_reg;
        col_last = (fps_pkg::dim_t'(col_cur) == row_length_reg - fps_pkg::dim_t'(1));
        row_last = (fps_pkg::dim_t'(row_reg) == row_count_reg - fps_pkg::dim_t'(1));
    end

    assign pos.col      = col_cur;
    assign pos.row      = row_reg;
    assign pos.interior = (row_reg >= fps_pkg::ROW_BITS'(2)) &&
                          (col_cur >= fps_pkg::COL_BITS'(2));
    assign pos.last     = row_last && col_last;

    // Take register writes (a known register restarts the frame) or advance over the raster
    always_comb
    begin
        row_length_next = row_length_reg;
        row_count_next  = row_count_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        if (cfg_fire)
        begin
            unique case (fps_pkg::cfg_reg_t'(cfg.index))
                fps_pkg::CFG_ROW_LENGTH:
                begin
                    row_length_next = fps_pkg::clamp_dim(cfg.data,
                        fps_pkg::DIM_BITS'(fps_pkg::MAX_ROW_LENGTH));
                    col_next = '0;
                    row_next = '0;
                end
                fps_pkg::CFG_ROW_COUNT:
                begin
                    row_count_next = fps_pkg::clamp_dim(cfg.data,
                        fps_pkg::DIM_BITS'(fps_pkg::ROW_COUNT_LIMIT));
                    col_next = '0;
                    row_next = '0;
                end
                default:
                begin
                    row_length_next = row_length_reg;
                end
            endcase
        end
        else if (advance)
        begin
            if (col_last)
            begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + fps_pkg::ROW_BITS'(1);
            end
            else
            begin
                col_next = col_cur + fps_pkg::COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg <= fps_pkg::DIM_BITS'(fps_pkg::MAX_ROW_LENGTH);
            row_count_reg  <= fps_pkg::DIM_BITS'(fps_pkg::ROW_COUNT_LIMIT);
            col_reg        <= '0;
            row_reg        <= '0;
        end
        else
        begin
            row_length_reg <= row_length_next;
            row_count_reg  <= row_count_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
        end
    end

endmodule

// ===== design/fps_stencil.sv =====
// ----------------------------------------------------------------------------
// Five-point stencil datapath
// Stage register for the accepted sample, the middle-row window, the neighbor
// delay, the stencil sum and the result register.
// ----------------------------------------------------------------------------
module fps_stencil (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [fps_pkg::SAMPLE_BITS-1:0] sample,
    input  fps_pkg::pos_t                 pos,
    input  logic [fps_pkg::LINE_BITS-1:0] line_rd,
    output fps_pkg::line_wr_t             line_wr,
    output logic                          in_ready,
    output logic                          idle,
    fps_result_if.source                  res
);

    localparam int S = fps_pkg::SAMPLE_BITS;

    logic                         s1_valid_reg, s1_valid_next;
    fps_pkg::sample_t             s1_sample_reg;
    logic [fps_pkg::COL_BITS-1:0] s1_col_reg;
    logic                         s1_interior_reg;
    logic                         s1_last_reg;

    fps_pkg::sample_t             win_reg [3];
    fps_pkg::sample_t             nd_reg  [2];

    logic                         out_valid_reg, out_valid_next;
    fps_pkg::result_t             half_laplacian_reg;
    logic                         last_of_frame_reg;

    logic                         s1_fire;
    fps_pkg::sample_t             rd_prev;
    fps_pkg::sample_t             rd_older;
    fps_pkg::result_t             stencil_sum;

    assign rd_prev  = fps_pkg::sample_t'(line_rd[S-1:0]);
    assign rd_older = fps_pkg::sample_t'(line_rd[2*S-1:S]);

    // Stage fires when the result register is free or being drained
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || res.ready);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign idle     = !s1_valid_reg && !out_valid_reg;

    // Neighbors plus left/right minus four times the center
    assign stencil_sum = fps_pkg::widen(nd_reg[1]) + fps_pkg::widen(nd_reg[0])
                       + fps_pkg::widen(win_reg[1]) + fps_pkg::widen(rd_prev)
                       - (fps_pkg::widen(win_reg[2]) <<< 2);

    // Shift the line buffers: previous row moves to older row
    assign line_wr.en   = s1_fire;
    assign line_wr.addr = s1_col_reg;
    assign line_wr.data = {rd_prev, s1_sample_reg};

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_fire)
            out_valid_next = s1_interior_reg;
        else if (res.ready)
            out_valid_next = 1'b0;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the accepted sample and its position
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg   <= fps_pkg::sample_t'(sample);
            s1_col_reg      <= pos.col;
            s1_interior_reg <= pos.interior;
            s1_last_reg     <= pos.last;
        end
    end

    // Advance the window and neighbor delay
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg[0] <= '0;
            win_reg[1] <= '0;
            win_reg[2] <= '0;
            nd_reg[0]  <= '0;
            nd_reg[1]  <= '0;
        end
        else if (s1_fire)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= rd_prev;
            nd_reg[1]  <= rd_older;
            nd_reg[0]  <= s1_sample_reg;
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            half_laplacian_reg <= stencil_sum;
            last_of_frame_reg  <= s1_last_reg;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.half_laplacian = half_laplacian_reg;
    assign res.last_of_frame  = last_of_frame_reg;

endmodule

// ===== design/five_point_stencil_stream_unit.sv =====
// ----------------------------------------------------------------------------
// Five-point stencil stream unit
// Takes 16-bit signed Q8.8 grid samples in raster order and, for each interior
// cell, returns up + down + left + right - 4 * center as a 19-bit signed value
// with 9 fraction bits (half the discrete Laplacian, exact). Edge cells give no
// result; last_of_frame marks the final interior cell, after which the next
// sample starts a new grid. Rate is one sample per clock while results are taken,
// set by the line buffer RAM, which does one read and one write per sample. A
// result passes the stage register and then the result register once its
// completing sample (the bottom-right neighbor) is taken, held while stalled.
// Grid size comes from row_length (index 0) and row_count (index 1), each
// clamped to 3..1024; a write to either restarts the frame, and any write is
// taken only while the unit is empty and no sample is offered. Line buffer
// contents are undefined after reset; unwritten entries never reach a result.
// ----------------------------------------------------------------------------
`include "five_point_stencil_stream_unit_assert.svh"

module five_point_stencil_stream_unit (
    input  logic          clk,
    input  logic          rst_n,
    fps_sample_if.sink    samples,
    fps_result_if.source  results,
    fps_cfg_if.sink       cfg
);

    fps_pkg::pos_t     pos;
    fps_pkg::line_wr_t line_wr;
    logic [fps_pkg::LINE_BITS-1:0] line_rd;
    logic              accept;
    logic              in_ready;
    logic              idle;
    logic              cfg_open;

    assign samples.ready = in_ready;
    assign accept        = samples.valid && in_ready;
    // Configuration waits for an empty pipeline and a quiet input
    assign cfg_open      = idle && !samples.valid;

    // Raster position and grid dimensions
    fps_position u_position (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cfg_open (cfg_open),
        .advance  (accept),
        .pos      (pos)
    );

    // Two line buffers packed side by side
    fps_ram #(
        .WIDTH (fps_pkg::LINE_BITS),
        .DEPTH (fps_pkg::MAX_ROW_LENGTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (line_wr.en),
        .wr_addr (line_wr.addr),
        .wr_data (line_wr.data),
        .rd_en   (accept),
        .rd_addr (pos.col),
        .rd_data (line_rd)
    );

    // Window, stencil arithmetic and result register
    fps_stencil u_stencil (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .sample   (samples.sample),
        .pos      (pos),
        .line_rd  (line_rd),
        .line_wr  (line_wr),
        .in_ready (in_ready),
        .idle     (idle),
        .res      (results)
    );

    // Line buffer read and write never collide on one column
    `FPS_ASSERT_IMPLIES(a_no_line_collision, clk, rst_n, line_wr.en && accept, line_wr.addr != pos.col)

    // The final cell of a grid wraps the raster to the origin
    `FPS_ASSERT_NEXT(a_frame_wrap, clk, rst_n, accept && pos.last, pos.col == '0 && pos.row == '0)

    // Configuration is open only while no result is pending and no sample waits
    `FPS_ASSERT_IMPLIES(a_cfg_when_idle, clk, rst_n, cfg.ready, !results.valid && !samples.valid)

endmodule

// ===== tb/sv/five_point_stencil_stream_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Five-point stencil stream unit testbench
// Drives raster grids of samples through the unit with random valid and ready
// gaps, and predicts every interior-cell result in a line-buffer model of its
// own. Grid sizes change between runs of samples, including clamped and
// ignored register writes. Results are checked field by field, in order.
// ----------------------------------------------------------------------------
module five_point_stencil_stream_unit_tb;
    import fps_pkg::*;

    localparam int          DRAIN_CYCLES   = 4;
    localparam int          RANDOM_ITEMS   = 1850;
    localparam int          TOP_SIZE_ITEMS = 32;
    localparam int unsigned CYCLE_LIMIT    = 1_000_000;

    // Register indexes past the end of the register list
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_LO = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_HI = 2'd3;

    localparam sample_t SAMPLE_MAX  = 16'sh7FFF;
    localparam sample_t SAMPLE_MIN  = 16'sh8000;
    localparam result_t PEAK_RESULT = 19'sd262140;

    typedef enum logic {STEP_CONFIG, STEP_SAMPLE} step_kind_t;

    typedef struct packed {
        step_kind_t                kind;
        logic [CFG_INDEX_BITS-1:0] reg_index;
        logic [SAMPLE_BITS-1:0]    value;
        logic                      typed;
        result_t                   want_half;
        logic                      want_last;
    } step_t;

    typedef struct packed {
        result_t half_laplacian;
        logic    last_of_frame;
    } stencil_result_t;

    // Directed steps: clamped and ignored writes, then two 3x3 grids with
    // the largest positive and negative stencil values
    localparam int DIRECTED_COUNT = 22;
    localparam step_t DIRECTED_STEPS [DIRECTED_COUNT] = '{
        '{STEP_CONFIG, CFG_ROW_LENGTH, 16'h0000, 1'b0, '0, 1'b0},
        '{STEP_CONFIG, CFG_ROW_COUNT,  16'h0002, 1'b0, '0, 1'b0},
        '{STEP_CONFIG, CFG_UNUSED_LO,  16'h07FF, 1'b0, '0, 1'b0},
        '{STEP_CONFIG, CFG_UNUSED_HI,  16'h0000, 1'b0, '0, 1'b0},
        '{STEP_SAMPLE, 2'd0, SAMPLE_MIN, 1'b0, '0, 1'b0},
        '{STEP_SAMPLE, 2'd0, SAMPLE_MAX, 1'b0, '0, 1'b0},
        '{STEP_SAMPLE, 2'd0, SAMPLE_MIN, 1'b0, '0, 1'b0},
        '{STEP_SAMPLE, 2'd0, SAMPLE_MAX, 1'b0, '0, 1'b0},
        '{STEP_SAMPLE, 2'd0, SAMPLE_MIN, 1'b0, '0, 1'b0},
        '{STEP_SAMPLE, 2'd0, SAMPLE_MAX, 1'b0, '0, 1'b0},
        '{STEP_SAMPLE, 2'd0, SAMPLE_MIN, 1'b0, '0, 1'b0},
        '{STEP_SAMPLE, 2'd0, SAMPLE_MAX, 1'b0, '0, 1'b0},
        '{STEP_SAMPLE, 2'd0, SAMPLE_MIN, 1'b1, PEAK_RESULT, 1'b1},
        '{STEP_SAMPLE, 2'd0, SAMPLE_MAX, 1'b0, '0, 1'b0},
        '{STEP_SAMPLE, 2'd0, SAMPLE_MIN, 1'b0, '0, 1'b0},
        '{STEP_SAMPLE, 2'd0, SAMPLE_MAX, 1'b0, '0, 1'b0},
        '{STEP_SAMPLE, 2'd0, SAMPLE_MIN, 1'b0, '0, 1'b0},
        '{STEP_SAMPLE, 2'd0, SAMPLE_MAX, 1'b0, '0, 1'b0},
        '{STEP_SAMPLE, 2'd0, SAMPLE_MIN, 1'b0, '0, 1'b0},
        '{STEP_SAMPLE, 2'd0, SAMPLE_MAX, 1'b0, '0, 1'b0},
        '{STEP_SAMPLE, 2'd0, SAMPLE_MIN, 1'b0, '0, 1'b0},
        '{STEP_SAMPLE, 2'd0, SAMPLE_MAX, 1'b1, -PEAK_RESULT, 1'b1}
    };

    logic        clk;
    logic        rst_n;
    int unsigned cycle_count = 0;
    int unsigned mismatch_count = 0;
    bit          steady_flow = 1'b0;

    stencil_result_t pending_results [$];

    // Grid model: line buffers, neighbor window and raster position
    dim_t        row_length_reg;
    dim_t        row_count_reg;
    sample_t     upper_line [MAX_ROW_LENGTH];
    sample_t     top_line [MAX_ROW_LENGTH];
    sample_t     middle_cells [3];
    sample_t     vertical_cells [2];
    int unsigned next_col;
    int unsigned next_row;

    fps_sample_if sample_bus ();
    fps_result_if result_bus ();
    fps_cfg_if    cfg_bus ();

    five_point_stencil_stream_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_bus),
        .results (result_bus),
        .cfg     (cfg_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // End a hung run
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("five_point_stencil_stream_unit_tb failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    function automatic int unsigned dim_in_use(input dim_t raw, input int unsigned ceiling);
        int unsigned value;
        value = raw;
        if (value < MIN_DIM)
            value = MIN_DIM;
        else if (value > ceiling)
            value = ceiling;
        return value;
    endfunction

    function automatic int unsigned grid_area();
        return dim_in_use(row_length_reg, MAX_ROW_LENGTH) *
               dim_in_use(row_count_reg, ROW_COUNT_LIMIT);
    endfunction

    function automatic void reset_grid_model();
        row_length_reg = DIM_BITS'(MAX_ROW_LENGTH);
        row_count_reg  = DIM_BITS'(ROW_COUNT_LIMIT);
        foreach (upper_line[i])
        begin
            upper_line[i] = '0;
            top_line[i]   = '0;
        end
        middle_cells   = '{default: '0};
        vertical_cells = '{default: '0};
        next_col = 0;
        next_row = 0;
    endfunction

    // Take a register write; a known register restarts the grid
    function automatic void apply_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                           input dim_t data);
        if (idx == CFG_ROW_LENGTH)
        begin
            row_length_reg = data;
            next_col = 0;
            next_row = 0;
        end
        else if (idx == CFG_ROW_COUNT)
        begin
            row_count_reg = data;
            next_col = 0;
            next_row = 0;
        end
    endfunction

    // Advance the grid by one sample; a result is due once the sample
    // completes the bottom-right neighbor of an interior cell
    function automatic void stencil_step(input sample_t s, output bit produced,
                                         output stencil_result_t res);
        int unsigned width;
        int unsigned height;
        int unsigned c;
        int unsigned r;
        int          total;
        sample_t     above;
        width  = dim_in_use(row_length_reg, MAX_ROW_LENGTH);
        height = dim_in_use(row_count_reg, ROW_COUNT_LIMIT);
        c = next_col;
        r = next_row;
        if (c >= width)
            c = 0;

        middle_cells[0] = middle_cells[1];
        middle_cells[1] = middle_cells[2];
        middle_cells[2] = upper_line[c];

        produced = (r >= 2) && (c >= 2);
        total = vertical_cells[1] + vertical_cells[0] + middle_cells[0] + middle_cells[2]
              - 4 * middle_cells[1];
        res.half_laplacian = result_t'(total);
        res.last_of_frame  = (r == height - 1) && (c == width - 1);

        above         = top_line[c];
        top_line[c]   = upper_line[c];
        upper_line[c] = s;
        vertical_cells[1] = above;
        vertical_cells[0] = s;

        c++;
        if (c >= width)
        begin
            c = 0;
            r++;
            if (r >= height)
                r = 0;
        end
        next_col = c;
        next_row = r;
    endfunction

    function automatic sample_t random_sample();
        sample_t value;
        case ($urandom_range(0, 7))
            0:       value = SAMPLE_MAX;
            1:       value = SAMPLE_MIN;
            2:       value = '0;
            default: value = sample_t'($urandom);
        endcase
        return value;
    endfunction

    // Raw register value for a grid size; below-minimum values clamp to 3
    function automatic dim_t raw_dim(input int unsigned size);
        dim_t value;
        if (size == MIN_DIM && $urandom_range(0, 1) == 1)
            value = DIM_BITS'($urandom_range(0, 2));
        else
            value = DIM_BITS'(size);
        return value;
    endfunction

    // Write one register once the unit has settled
    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx, input dim_t data);
        sample_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do
            @(posedge clk);
        while (cfg_bus.ready !== 1'b1);
        cfg_bus.valid <= 1'b0;
        apply_register(idx, data);
    endtask

    // Offer one sample request and record what it should produce
    task automatic send_sample(input sample_t s, input bit typed, input stencil_result_t typed_res);
        int unsigned     gap;
        bit              produced;
        stencil_result_t res;
        gap = steady_flow ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            sample_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_bus.valid  <= 1'b1;
        sample_bus.sample <= s;
        do
            @(posedge clk);
        while (sample_bus.ready !== 1'b1);
        stencil_step(s, produced, res);
        if (typed)
            pending_results.push_back(typed_res);
        else if (produced)
            pending_results.push_back(res);
    endtask

    task automatic send_random_samples(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            send_sample(random_sample(), 1'b0, '0);
    endtask

    // Accept results with random stalls
    initial
    begin : accept_results
        int unsigned stall;
        result_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = steady_flow ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                result_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(result_bus.valid === 1'b1 && result_bus.ready === 1'b1));
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin : check_results
        stencil_result_t want;
        if (rst_n === 1'b1 && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result %0d",
                                          $signed(result_bus.half_laplacian)));
            else
            begin
                want = pending_results.pop_front();
                if (result_bus.half_laplacian !== want.half_laplacian)
                    report_mismatch($sformatf("half_laplacian %0d, want %0d",
                                              $signed(result_bus.half_laplacian),
                                              want.half_laplacian));
                if (result_bus.last_of_frame !== want.last_of_frame)
                    report_mismatch($sformatf("last_of_frame %b, want %b",
                                              result_bus.last_of_frame,
                                              want.last_of_frame));
            end
        end
    end

    initial
    begin : stimulus
        stencil_result_t typed_res;
        int unsigned     random_sent;
        int unsigned     width;
        int unsigned     height;
        int unsigned     area;
        int unsigned     count;

        rst_n             <= 1'b0;
        sample_bus.valid  <= 1'b0;
        sample_bus.sample <= '0;
        cfg_bus.valid     <= 1'b0;
        cfg_bus.index     <= CFG_ROW_LENGTH;
        cfg_bus.data      <= '0;
        reset_grid_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed steps
        foreach (DIRECTED_STEPS[i])
        begin
            if (DIRECTED_STEPS[i].kind == STEP_CONFIG)
                write_register(DIRECTED_STEPS[i].reg_index,
                               DIM_BITS'(DIRECTED_STEPS[i].value));
            else
            begin
                typed_res.half_laplacian = DIRECTED_STEPS[i].want_half;
                typed_res.last_of_frame  = DIRECTED_STEPS[i].want_last;
                send_sample(sample_t'(DIRECTED_STEPS[i].value), DIRECTED_STEPS[i].typed,
                            typed_res);
            end
        end

        // Random grids: mostly whole frames, some cut short by a restart
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            steady_flow = ($urandom_range(0, 3) == 0);
            width  = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(3, 12);
            height = $urandom_range(3, 8);
            case ($urandom_range(0, 7))
                0: write_register(CFG_ROW_LENGTH, raw_dim(width));
                1: write_register(CFG_ROW_COUNT, raw_dim(height));
                2: write_register($urandom_range(0, 1) ? CFG_UNUSED_LO : CFG_UNUSED_HI,
                                  DIM_BITS'($urandom));
                3:
                begin
                    write_register(CFG_ROW_COUNT, raw_dim(height));
                    write_register(CFG_ROW_LENGTH, raw_dim(width));
                end
                default:
                begin
                    write_register(CFG_ROW_LENGTH, raw_dim(width));
                    write_register(CFG_ROW_COUNT, raw_dim(height));
                end
            endcase
            area  = grid_area();
            count = $urandom_range(1, 3) * area;
            if ($urandom_range(0, 3) == 0)
                count = $urandom_range(1, area - 1) + (($urandom_range(0, 1) == 1) ? area : 0);
            // Stop at the item budget
            if (count > RANDOM_ITEMS - random_sent)
                count = RANDOM_ITEMS - random_sent;
            send_random_samples(count);
            random_sent += count;
        end

        // Oversized writes clamp to the largest grid; run a short burst into it
        steady_flow = 1'b0;
        write_register(CFG_ROW_LENGTH, DIM_BITS'(2047));
        write_register(CFG_ROW_COUNT, DIM_BITS'(2047));
        send_random_samples(TOP_SIZE_ITEMS);

        // Drain and finish
        sample_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES * 2) @(posedge clk);
        if (mismatch_count == 0)
            $display("five_point_stencil_stream_unit_tb passed");
        else
            $display("five_point_stencil_stream_unit_tb failed");
        $finish;
    end

endmodule
